// File: rtl/sbtc_pkg.sv
// ---------------------------------------------------------------------------
// sbtc_pkg: shared types and tables for the six-bit text codec
// Holds the 64-entry alphabet, its inverse lookup and the result batch type.
// ---------------------------------------------------------------------------
package sbtc_pkg;

	localparam int unsigned ALPHA_SIZE = 64;
	localparam int unsigned CODE_W     = 6;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned GROUP_W    = 24;
	localparam int unsigned MAX_RES    = 4;
	localparam int unsigned NUM_W      = 3;

	// Printable alphabet, code 0 first
	localparam logic [BYTE_W-1:0] ALPHABET [ALPHA_SIZE] = '{
		8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
		8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h30, 8'h31, 8'h32,
		8'h33, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h40, 8'h41,
		8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
		8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52,
		8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5A, 8'h5B,
		8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h68,
		8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h70, 8'h71, 8'h72
	};

	// Results caused by one input word, vals[0] goes out first
	typedef struct packed {
		logic [NUM_W-1:0]                num;
		logic                            err;
		logic [MAX_RES-1:0][BYTE_W-1:0] vals;
	} sbtc_batch_t;

	// Character for a six-bit code
	function automatic logic [BYTE_W-1:0] enc_char(input logic [CODE_W-1:0] c);
		return ALPHABET[c];
	endfunction

	// Inverse lookup: bit 6 set means the character is not in the alphabet
	function automatic logic [CODE_W:0] dec_code(input logic [BYTE_W-1:0] ch);
		logic [CODE_W:0] code;
		code = {1'b1, {CODE_W{1'b0}}};
		for (int i = 0; i < ALPHA_SIZE; i++) begin
			if (ALPHABET[i] == ch) begin
				code = {1'b0, CODE_W'(i)};
			end
		end
		return code;
	endfunction

endpackage

// File: rtl/sbtc_group.sv
// ---------------------------------------------------------------------------
// sbtc_group: group collector and converter
// Keeps the partial group and the mode register, and turns each accepted
// word into a batch of zero to four results in one pass of logic.
// ---------------------------------------------------------------------------
module sbtc_group
	import sbtc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              decode_mode_we,
	input  logic              decode_mode,
	input  logic              item_acc,
	input  logic              kind,
	input  logic [7:0]        data_value,
	output sbtc_batch_t       batch
);

	logic                 mode_q;
	logic [GROUP_W-1:0]   bits_q;
	logic [1:0]           cnt_q;
	logic [GROUP_W-1:0]   nxt_bits;
	logic [1:0]           nxt_cnt;
	logic [GROUP_W-1:0]   ins_byte;
	logic [GROUP_W-1:0]   ins_code;
	logic [GROUP_W-1:0]   merged;
	logic [CODE_W:0]      code;

	// Four characters of a 24-bit group, high bits first
	function automatic sbtc_batch_t make_chars(input logic [GROUP_W-1:0] w);
		sbtc_batch_t b;
		b.num     = NUM_W'(MAX_RES);
		b.err     = 1'b0;
		b.vals[0] = enc_char(w[23:18]);
		b.vals[1] = enc_char(w[17:12]);
		b.vals[2] = enc_char(w[11:6]);
		b.vals[3] = enc_char(w[5:0]);
		return b;
	endfunction

	// First n bytes of a 24-bit group
	function automatic sbtc_batch_t make_bytes(input logic [GROUP_W-1:0] w,
	                                           input logic [NUM_W-1:0] n);
		sbtc_batch_t b;
		b.num     = n;
		b.err     = 1'b0;
		b.vals[0] = w[23:16];
		b.vals[1] = w[15:8];
		b.vals[2] = w[7:0];
		b.vals[3] = '0;
		return b;
	endfunction

	// Place the incoming byte or code at the next free slot
	always_comb begin
		code = dec_code(data_value);
		case (cnt_q)
			2'd0: ins_byte = {data_value, 16'h0};
			2'd1: ins_byte = {8'h0, data_value, 8'h0};
			default: ins_byte = {16'h0, data_value};
		endcase
		case (cnt_q)
			2'd0: ins_code = {code[CODE_W-1:0], 18'h0};
			2'd1: ins_code = {6'h0, code[CODE_W-1:0], 12'h0};
			2'd2: ins_code = {12'h0, code[CODE_W-1:0], 6'h0};
			default: ins_code = {18'h0, code[CODE_W-1:0]};
		endcase
	end

	// Next group state and the result batch
	always_comb begin
		nxt_bits = bits_q;
		nxt_cnt  = cnt_q;
		batch    = '0;
		merged   = bits_q | (mode_q ? ins_code : ins_byte);
		if (!mode_q) begin
			if (kind) begin
				if (cnt_q != 2'd0) begin
					batch = make_chars(bits_q);
				end
				nxt_bits = '0;
				nxt_cnt  = '0;
			end else if (cnt_q == 2'd2) begin
				batch    = make_chars(merged);
				nxt_bits = '0;
				nxt_cnt  = '0;
			end else begin
				nxt_bits = merged;
				nxt_cnt  = cnt_q + 2'd1;
			end
		end else begin
			if (kind) begin
				if (cnt_q >= 2'd2) begin
					batch = make_bytes(bits_q, NUM_W'(cnt_q) - NUM_W'(1));
				end
				nxt_bits = '0;
				nxt_cnt  = '0;
			end else if (code[CODE_W]) begin
				// character outside the alphabet: one error result, group dropped
				batch.num = NUM_W'(1);
				batch.err = 1'b1;
				nxt_bits  = '0;
				nxt_cnt   = '0;
			end else if (cnt_q == 2'd3) begin
				batch    = make_bytes(merged, NUM_W'(3));
				nxt_bits = '0;
				nxt_cnt  = '0;
			end else begin
				nxt_bits = merged;
				nxt_cnt  = cnt_q + 2'd1;
			end
		end
	end

	// Mode register and partial group; a mode write drops the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			bits_q <= '0;
			cnt_q  <= '0;
		end else if (decode_mode_we) begin
			mode_q <= decode_mode;
			bits_q <= '0;
			cnt_q  <= '0;
		end else if (item_acc) begin
			bits_q <= nxt_bits;
			cnt_q  <= nxt_cnt;
		end
	end

endmodule

// File: rtl/sbtc_serial.sv
// ---------------------------------------------------------------------------
// sbtc_serial: result register
// Holds one batch and shifts it out one result word per cycle while res_stall is low.
// ---------------------------------------------------------------------------
module sbtc_serial
	import sbtc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  sbtc_batch_t  batch,
	output logic         busy,
	output logic         res_valid,
	input  logic         res_stall,
	output logic [7:0]   value,
	output logic         is_error,
	output logic         last
);

	logic [NUM_W-1:0]                num_s1;
	logic                            err_s1;
	logic [MAX_RES-1:0][BYTE_W-1:0] vals_s1;
	logic                            take;

	assign res_valid = (num_s1 != '0);
	assign take      = res_valid && !res_stall;
	assign value     = vals_s1[0];
	assign is_error  = err_s1;
	assign last      = (num_s1 == NUM_W'(1));
	// busy while a result stays in the register after this cycle
	assign busy      = (num_s1 > NUM_W'(1)) || (last && res_stall);

	// Count of pending results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_s1 <= '0;
		end else if (load) begin
			num_s1 <= batch.num;
		end else if (take) begin
			num_s1 <= num_s1 - NUM_W'(1);
		end
	end

	// Result words, shifted toward slot 0
	always_ff @(posedge clk) begin
		if (load) begin
			vals_s1 <= batch.vals;
			err_s1  <= batch.err;
		end else if (take) begin
			vals_s1 <= {8'h0, vals_s1[MAX_RES-1:1]};
		end
	end

endmodule

// File: rtl/six_bit_text_codec_top.sv
// ---------------------------------------------------------------------------
// six_bit_text_codec_top: BinHex six-bit alphabet codec
// Encodes bytes to printable characters or decodes them back, by group.
// ---------------------------------------------------------------------------
// An input word is taken whenever the result register is empty or is
// handing over its final result; its group is converted in that same
// cycle and the results land in the result register. Results leave one
// word per cycle through the single result port while res_stall is low,
// so a word that completes a group holds the input until its final result
// is handed over: four results for an encoded group or non-empty flush, up
// to three for a decoded group, one for a bad character. Words that only
// fill the group add no results and go at one per cycle while item_stall is
// low. A stream's input rate is set by the completing word waiting for its
// batch to drain. Writing decode_mode drops any partial group and must be
// done only while the codec is idle.
module six_bit_text_codec_top
	import sbtc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        decode_mode_we,
	input  logic        decode_mode,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [7:0]  data_value,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  value,
	output logic        is_error,
	output logic        last
);

	sbtc_batch_t batch;
	logic        busy;
	logic        item_acc;

	assign item_stall = busy;
	assign item_acc   = item_valid && !busy;

	// Group state and conversion
	sbtc_group u_group (
		.clk            (clk),
		.arst_n         (arst_n),
		.decode_mode_we (decode_mode_we),
		.decode_mode    (decode_mode),
		.item_acc       (item_acc),
		.kind           (kind),
		.data_value     (data_value),
		.batch          (batch)
	);

	// Result register and output shifter
	sbtc_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (item_acc),
		.batch     (batch),
		.busy      (busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value     (value),
		.is_error  (is_error),
		.last      (last)
	);

	// Input only waits on pending results
	a_stall_needs_results: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> res_valid)
		else $error("input stalled with no result pending");

	// A batch is not cut short
	a_batch_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last |=> res_valid)
		else $error("result batch ended before its last word");

	// An error result stands alone
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_error |-> last && (value == 8'h00))
		else $error("error result not a single zero word");

endmodule
